// File: rtl/core/integer_to_ascii_formatter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter core.
// Each macro expands to one labelled concurrent assertion with a reset guard.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ITOA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, codes and character helpers shared by the formatter core and its
// digit extraction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int CNT_W      = 7;
    localparam int MAX_DIGITS = 11;
    localparam int DIG_IDX_W  = 4;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;

    localparam logic [1:0] SIZE_SHORT = 2'd1;

    // x / 10 == (x * RECIP_DEC) >> RECIP_SHIFT for every 32-bit x.
    localparam logic [31:0] RECIP_DEC   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_LA    = 8'h61;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  op;
        logic [1:0]  size_mod;
        logic [6:0]  field_width;
        logic        left_justify;
        logic        zero_pad;
    } itoa_in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } itoa_out_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } radix_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [3:0]  remainder;
    } div_result_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] letter_base;
        letter_base = upper ? CHAR_UA : CHAR_LA;
        if (d < 4'd10) begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return letter_base + {4'b0000, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/itoa_div_step.sv
// ----------------------------------------------------------------------------
// itoa_div_step
// Shared two-stage digit unit: divides a 32-bit magnitude by 8, 10 or 16 and
// returns the quotient and the low digit. Decimal uses a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_div_step (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [31:0]          dividend,
    input  wire itoa_pkg::radix_t     radix,
    output itoa_pkg::div_result_t     result
);

    logic                 s1_valid_reg;
    logic [31:0]          s1_dividend_reg;
    logic [31:0]          s1_quot_reg;
    itoa_pkg::radix_t     s1_radix_reg;
    logic [31:0]          quot_next;
    logic [63:0]          product;

    logic                 done_reg;
    logic [31:0]          quot_reg;
    logic [3:0]           rem_reg;
    logic [31:0]          back_mul;
    logic [31:0]          diff;

    always_comb begin
        product = 64'(dividend) * 64'(itoa_pkg::RECIP_DEC);
        case (radix)
            itoa_pkg::RADIX_OCT: quot_next = dividend >> 3;
            itoa_pkg::RADIX_HEX: quot_next = dividend >> 4;
            default:             quot_next = 32'(product >> itoa_pkg::RECIP_SHIFT);
        endcase
    end

    // The remainder comes from the registered quotient multiplied back.
    always_comb begin
        case (s1_radix_reg)
            itoa_pkg::RADIX_OCT: back_mul = s1_quot_reg << 3;
            itoa_pkg::RADIX_HEX: back_mul = s1_quot_reg << 4;
            default:             back_mul = (s1_quot_reg << 3) + (s1_quot_reg << 1);
        endcase
        diff = s1_dividend_reg - back_mul;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            s1_dividend_reg <= dividend;
            s1_quot_reg     <= quot_next;
            s1_radix_reg    <= radix;
        end
        if (s1_valid_reg) begin
            quot_reg <= s1_quot_reg;
            rem_reg  <= diff[3:0];
        end
    end

    assign result.done      = done_reg;
    assign result.quotient  = quot_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: one integer in, its printf text out, one char a cycle
// while the output is not stalled. A text has D digits (1 to 11) and N characters (1 to
// 64); digits come from the shared digit unit, characters leave through the one-character
// output register. A new integer is taken only once the previous text is fully issued.
// Reset: synchronous, active low; the sequencer returns to idle and the output empties.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_core #(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire itoa_pkg::itoa_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output itoa_pkg::itoa_out_t      m_data
);

    localparam int CW = itoa_pkg::CNT_W;
    localparam int DW = itoa_pkg::DIG_IDX_W;

    itoa_pkg::state_t      state_reg, state_next;
    itoa_pkg::radix_t      radix_reg, radix_next;
    logic                  upper_reg, upper_next;
    logic                  neg_reg, neg_next;
    logic                  left_reg, left_next;
    logic                  zpad_reg, zpad_next;
    logic [CW-1:0]         width_reg, width_next;
    logic [DW-1:0]         ndig_reg, ndig_next;
    logic [3:0]            digit_reg [itoa_pkg::MAX_DIGITS];
    logic                  dig_we;

    logic [CW-1:0]         lead_end_reg, lead_end_next;
    logic [CW-1:0]         sign_end_reg, sign_end_next;
    logic [CW-1:0]         dig_start_reg, dig_start_next;
    logic [CW-1:0]         dig_end_reg, dig_end_next;
    logic [CW-1:0]         last_pos_reg, last_pos_next;
    logic [CW-1:0]         pos_reg, pos_next;

    itoa_pkg::itoa_out_t   out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  div_start;
    logic [31:0]           div_dividend;
    itoa_pkg::div_result_t div_res;

    logic                  accept;
    logic                  is_signed;
    logic [31:0]           raw;
    logic [CW-1:0]         width_sat;
    logic [CW-1:0]         len;
    logic [CW-1:0]         pad;
    logic [CW-1:0]         dig_off;
    logic [7:0]            emit_char;
    logic                  out_free;

    itoa_div_step u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .radix    (radix_next),
        .result   (div_res)
    );

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == itoa_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Operand preparation at acceptance: size truncation with sign extension, and width saturation.
    always_comb begin
        is_signed = (s_data.op == itoa_pkg::OP_SDEC);
        raw       = s_data.value;
        if (s_data.size_mod == itoa_pkg::SIZE_SHORT) begin
            raw = {{16{is_signed && s_data.value[15]}}, s_data.value[15:0]};
        end
        width_sat = (s_data.field_width > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                          : s_data.field_width;
    end

    // Character at the current output position, and the text length and padding.
    always_comb begin
        dig_off = dig_end_reg - CW'(1) - pos_reg;
        if (pos_reg < lead_end_reg) begin
            emit_char = itoa_pkg::CHAR_SPACE;
        end else if (pos_reg < sign_end_reg) begin
            emit_char = itoa_pkg::CHAR_MINUS;
        end else if (pos_reg < dig_start_reg) begin
            emit_char = itoa_pkg::CHAR_ZERO;
        end else if (pos_reg < dig_end_reg) begin
            emit_char = itoa_pkg::digit_char(digit_reg[dig_off[DW-1:0]], upper_reg);
        end else begin
            emit_char = itoa_pkg::CHAR_SPACE;
        end
        len = CW'(ndig_reg) + CW'(neg_reg);
        pad = (width_reg > len) ? (width_reg - len) : '0;
    end

    always_comb begin
        state_next     = state_reg;
        radix_next     = radix_reg;
        upper_next     = upper_reg;
        neg_next       = neg_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        width_next     = width_reg;
        ndig_next      = ndig_reg;
        lead_end_next  = lead_end_reg;
        sign_end_next  = sign_end_reg;
        dig_start_next = dig_start_reg;
        dig_end_next   = dig_end_reg;
        last_pos_next  = last_pos_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        div_start      = 1'b0;
        div_dividend   = div_res.quotient;
        dig_we         = 1'b0;

        unique case (state_reg)
            itoa_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_data.op)
                        itoa_pkg::OP_OCT:  radix_next = itoa_pkg::RADIX_OCT;
                        itoa_pkg::OP_HEXL,
                        itoa_pkg::OP_HEXU: radix_next = itoa_pkg::RADIX_HEX;
                        default:           radix_next = itoa_pkg::RADIX_DEC;
                    endcase
                    upper_next   = (s_data.op == itoa_pkg::OP_HEXU);
                    neg_next     = is_signed && raw[31];
                    left_next    = s_data.left_justify;
                    zpad_next    = s_data.zero_pad && !s_data.left_justify;
                    width_next   = width_sat;
                    ndig_next    = '0;
                    div_start    = 1'b1;
                    div_dividend = (is_signed && raw[31]) ? (32'd0 - raw) : raw;
                    state_next   = itoa_pkg::ST_DIV;
                end
            end
            itoa_pkg::ST_DIV: begin
                if (div_res.done) begin
                    dig_we    = 1'b1;
                    ndig_next = ndig_reg + DW'(1);
                    if (div_res.quotient == 32'd0) begin
                        state_next = itoa_pkg::ST_SETUP;
                    end else begin
                        div_start = 1'b1;
                    end
                end
            end
            itoa_pkg::ST_SETUP: begin
                lead_end_next  = (!left_reg && !zpad_reg) ? pad : '0;
                sign_end_next  = lead_end_next + CW'(neg_reg);
                dig_start_next = sign_end_next + (zpad_reg ? pad : '0);
                dig_end_next   = dig_start_next + CW'(ndig_reg);
                last_pos_next  = len + pad - CW'(1);
                pos_next       = '0;
                state_next     = itoa_pkg::ST_EMIT;
            end
            itoa_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_next.out_char = emit_char;
                    out_next.last     = (pos_reg == last_pos_reg);
                    m_valid_next      = 1'b1;
                    pos_next          = pos_reg + CW'(1);
                    if (pos_reg == last_pos_reg) begin
                        state_next = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = itoa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= itoa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        radix_reg     <= radix_next;
        upper_reg     <= upper_next;
        neg_reg       <= neg_next;
        left_reg      <= left_next;
        zpad_reg      <= zpad_next;
        width_reg     <= width_next;
        ndig_reg      <= ndig_next;
        lead_end_reg  <= lead_end_next;
        sign_end_reg  <= sign_end_next;
        dig_start_reg <= dig_start_next;
        dig_end_reg   <= dig_end_next;
        last_pos_reg  <= last_pos_next;
        pos_reg       <= pos_next;
        out_reg       <= out_next;
    end

    // Digits are stored least significant first and read back in reverse.
    always_ff @(posedge aclk) begin
        if (dig_we) begin
            digit_reg[ndig_reg] <= div_res.remainder;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks on the formatter core, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_core_assert.svh"

module itoa_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire itoa_pkg::itoa_out_t m_data
);

    // A stalled output word must hold.
    `ITOA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "output word changed while stalled")

    // Once an integer is taken the core is busy on the following cycle.
    `ITOA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "core ready straight after accepting a word")

    // A character that is not the last is followed at once by the next one of the same text.
    `ITOA_ASSERT_NEXT(a_no_gap_mid_text, aclk, aresetn, m_valid && m_ready && !m_data.last, m_valid, "gap in the output before the text was complete")

    // When the core is ready, any word still waiting at the output closes its text.
    `ITOA_ASSERT_SAME(a_ready_only_after_last, aclk, aresetn, s_ready && m_valid, m_data.last, "core ready while a text is unfinished")

endmodule

bind integer_to_ascii_formatter_core itoa_checker u_itoa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// File: bench/integer_to_ascii_formatter_core_test.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_test: self-checking bench for the formatter
// Each request is formatted by a behavioural predictor and the expected
// characters are queued. Every character word from the core is compared
// with the oldest queued one. Directed corner cases come first, then random
// requests with bursts of idling on both channels.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_MAX = 64;
    localparam int RANDOM_REQUESTS = 260;
    localparam int QUIET_FROM = 220;

    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_UNUSED = 2'd3;

    class itoa_scoreboard;
        itoa_pkg::itoa_out_t expected_text[$];
        int unsigned         errors;

        function new();
            errors = 0;
        endfunction

        // Formats one accepted request and queues its characters.
        function void note_request(itoa_pkg::itoa_in_t req);
            logic [31:0]         raw;
            logic [31:0]         mag;
            logic [31:0]         base;
            logic [31:0]         d;
            int unsigned         width;
            int unsigned         len;
            int unsigned         npad;
            bit                  is_signed;
            bit                  upper;
            bit                  neg;
            bit                  left;
            bit                  zpad;
            logic [7:0]          digs[$];
            logic [7:0]          text[$];
            itoa_pkg::itoa_out_t word;

            raw       = req.value;
            is_signed = (req.op == itoa_pkg::OP_SDEC);
            upper     = (req.op == itoa_pkg::OP_HEXU);
            case (req.op)
                itoa_pkg::OP_OCT: begin
                    base = 32'd8;
                end
                itoa_pkg::OP_HEXL, itoa_pkg::OP_HEXU: begin
                    base = 32'd16;
                end
                default: begin
                    base = 32'd10;
                end
            endcase
            width = (req.field_width > FIELD_MAX) ? FIELD_MAX : req.field_width;
            left  = req.left_justify;
            zpad  = req.zero_pad && !left;

            if (req.size_mod == itoa_pkg::SIZE_SHORT) begin
                raw = (is_signed && raw[15]) ? {16'hFFFF, raw[15:0]} : {16'h0000, raw[15:0]};
            end
            neg = is_signed && raw[31];
            mag = neg ? (32'd0 - raw) : raw;

            do begin
                d = mag % base;
                if (d < 10) begin
                    digs.push_front(itoa_pkg::CHAR_ZERO + d[7:0]);
                end else begin
                    digs.push_front((upper ? itoa_pkg::CHAR_UA : itoa_pkg::CHAR_LA)
                                    + d[7:0] - 8'd10);
                end
                mag = mag / base;
            end while (mag != 0);

            len  = digs.size() + (neg ? 1 : 0);
            npad = (width > len) ? width - len : 0;

            if (!left && !zpad) begin
                repeat (npad) text.push_back(itoa_pkg::CHAR_SPACE);
            end
            // The sign goes ahead of any zero padding.
            if (neg) begin
                text.push_back(itoa_pkg::CHAR_MINUS);
            end
            if (zpad) begin
                repeat (npad) text.push_back(itoa_pkg::CHAR_ZERO);
            end
            foreach (digs[k]) text.push_back(digs[k]);
            if (left) begin
                repeat (npad) text.push_back(itoa_pkg::CHAR_SPACE);
            end

            foreach (text[k]) begin
                word.out_char = text[k];
                word.last     = (k == text.size() - 1);
                expected_text.push_back(word);
            end
        endfunction

        function void check_char(itoa_pkg::itoa_out_t got);
            itoa_pkg::itoa_out_t want;
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected character word, expected none, actual %02h last %0b",
                         $realtime, got.out_char, got.last);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (got.out_char !== want.out_char) begin
                $display("%0t: out_char mismatch, expected %02h, actual %02h",
                         $realtime, want.out_char, got.out_char);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $realtime, want.last, got.last);
                errors++;
            end
        endfunction

        function int unsigned waiting();
            return expected_text.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    itoa_pkg::itoa_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    itoa_pkg::itoa_out_t m_data;

    bit             idle_mode;
    int unsigned    stall_left;
    itoa_scoreboard sb;

    integer_to_ascii_formatter_core #(
        .MAX_WIDTH(FIELD_MAX)
    ) i_dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Both channels are observed at the rising edge, before the core updates.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
            end
            if (m_valid && m_ready) begin
                sb.check_char(m_data);
            end
        end
    end

    // The result side stalls in random bursts while idle mode is on.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (idle_mode && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    function automatic itoa_pkg::itoa_in_t make_request(logic [31:0] value, logic [2:0] op,
                                                        logic [1:0] size_mod,
                                                        logic [6:0] width,
                                                        logic left, logic zpad);
        itoa_pkg::itoa_in_t req;
        req.value        = value;
        req.op           = op;
        req.size_mod     = size_mod;
        req.field_width  = width;
        req.left_justify = left;
        req.zero_pad     = zpad;
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(itoa_pkg::itoa_in_t req);
        if (idle_mode && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_text();
        s_valid = 1'b0;
        while (sb.waiting() != 0) @(negedge aclk);
    endtask

    initial begin
        itoa_pkg::itoa_in_t directed[$];
        itoa_pkg::itoa_in_t req;
        logic [31:0]        value;

        sb         = new();
        idle_mode  = 1'b1;
        stall_left = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Zero in every conversion, including the unused codes.
        for (int code = 0; code < 8; code++) begin
            directed.push_back(make_request(32'd0, code[2:0], SIZE_NONE, 7'd0, 1'b0, 1'b0));
        end
        directed.push_back(make_request(32'h8000_0000, itoa_pkg::OP_SDEC, SIZE_NONE,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'h7FFF_FFFF, itoa_pkg::OP_SDEC, SIZE_LONG,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF, OP_UDEC, SIZE_NONE, 7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'hFFFF_FFFF, itoa_pkg::OP_OCT, SIZE_UNUSED,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'hDEAD_BEEF, itoa_pkg::OP_HEXL, SIZE_NONE,
                                        7'd12, 1'b0, 1'b0));
        directed.push_back(make_request(32'hDEAD_BEEF, itoa_pkg::OP_HEXU, SIZE_LONG,
                                        7'd12, 1'b1, 1'b0));
        // Negative values with zero padding, space padding and left justification.
        directed.push_back(make_request(-32'sd5, itoa_pkg::OP_SDEC, SIZE_NONE,
                                        7'd5, 1'b0, 1'b1));
        directed.push_back(make_request(-32'sd5, itoa_pkg::OP_SDEC, SIZE_NONE,
                                        7'd5, 1'b0, 1'b0));
        directed.push_back(make_request(-32'sd5, itoa_pkg::OP_SDEC, SIZE_NONE,
                                        7'd6, 1'b1, 1'b1));
        // Short modifier: sign extension only for signed decimal.
        directed.push_back(make_request(32'h1234_8000, itoa_pkg::OP_SDEC, itoa_pkg::SIZE_SHORT,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'hFFFF_7FFF, itoa_pkg::OP_SDEC, itoa_pkg::SIZE_SHORT,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'hABCD_FFFF, itoa_pkg::OP_HEXU, itoa_pkg::SIZE_SHORT,
                                        7'd0, 1'b0, 1'b0));
        directed.push_back(make_request(32'h0001_FFFF, OP_UDEC, itoa_pkg::SIZE_SHORT,
                                        7'd8, 1'b0, 1'b1));
        // Widths at and beyond the maximum.
        directed.push_back(make_request(32'd42, OP_UDEC, SIZE_NONE, 7'd64, 1'b0, 1'b1));
        directed.push_back(make_request(32'd42, itoa_pkg::OP_OCT, SIZE_NONE,
                                        7'd65, 1'b1, 1'b0));
        directed.push_back(make_request(-32'sd1, itoa_pkg::OP_SDEC, SIZE_NONE,
                                        7'd127, 1'b0, 1'b0));

        foreach (directed[k]) send_request(directed[k]);
        drain_text();

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n >= QUIET_FROM) begin
                idle_mode = 1'b0;
            end else if (n % 40 == 0) begin
                idle_mode = ($urandom_range(0, 3) != 0);
            end
            if (n == RANDOM_REQUESTS / 2) begin
                drain_text();
            end

            case ($urandom_range(0, 4))
                0: value = $urandom_range(0, 20);
                1: value = 32'd0 - $urandom_range(1, 1000);
                2: value = {16'($urandom_range(0, 65535)), 16'h0000}
                           | 32'($urandom_range(0, 65535));
                default: value = $urandom();
            endcase
            req.value        = value;
            req.op           = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'($urandom_range(0, 4));
            req.size_mod     = 2'($urandom_range(0, 3));
            req.field_width  = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(0, 16));
            req.left_justify = 1'($urandom_range(0, 1));
            req.zero_pad     = 1'($urandom_range(0, 1));
            send_request(req);
        end
        s_valid = 1'b0;

        while (sb.waiting() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.waiting() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/itoa_pkg.sv
rtl/core/itoa_div_step.sv
rtl/core/integer_to_ascii_formatter_core.sv
rtl/core/itoa_checker.sv
bench/integer_to_ascii_formatter_core_test.sv
